### design/tas_pkg.sv
// ----------------------------------------------------------------------------
// Tile attribute scanner package
// Shared sizes and request codes for the tile attribute scanner.
// ----------------------------------------------------------------------------
package tas_pkg;

  localparam int unsigned TILE_COUNT = 1024;
  localparam int unsigned IDX_W      = $clog2(TILE_COUNT);
  localparam int unsigned BYTE_W     = 8;

  localparam logic [1:0] REQ_VIDEO  = 2'd0;
  localparam logic [1:0] REQ_COLOUR = 2'd1;
  localparam logic [1:0] REQ_PORT   = 2'd2;
  localparam logic [1:0] REQ_SCAN   = 2'd3;

endpackage

### design/tas_ram.sv
// ----------------------------------------------------------------------------
// Tile attribute scanner RAM
// Single-port synchronous RAM with a registered read port.
// ----------------------------------------------------------------------------
module tas_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/tile_attribute_scanner_unit.sv
// ----------------------------------------------------------------------------
// Tile attribute scanner
// Holds video, colour and dirty stores of a 32x32 tile screen and emits a
// tile descriptor for each scan of a dirty (or forced) tile.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake             | Payload
//  --------+-----------------------+--------------------------------------------
//  in      | in_valid_i/in_ready_o | req_type, tile_offset, write_byte, force_all
//  out     | out_valid_o/out_ready_i | tile_column, tile_row, tile_code,
//          |                       | palette_select, graphics_bank, mirror_both
//
// After reset a clearing pass over every tile fills the stores; no transfer is
// taken on the input during it. Video and port writes return straight to idle.
// A colour write marks the neighbour dirty in ST_NEIGH; a scan passes ST_SCAN1
// and ST_SCAN2, as the colour store has one port and a scan reads two colour
// bytes from it. A scan result sits in an output register; in ST_SCAN2 the
// next item is held off only while that register is full and a new result is due.
// ----------------------------------------------------------------------------
module tile_attribute_scanner_unit
  import tas_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [1:0]        req_type_i,
  input  logic [IDX_W-1:0]  tile_offset_i,
  input  logic [BYTE_W-1:0] write_byte_i,
  input  logic              force_all_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output logic [4:0]        tile_column_o,
  output logic [4:0]        tile_row_o,
  output logic [8:0]        tile_code_o,
  output logic [4:0]        palette_select_o,
  output logic              graphics_bank_o,
  output logic              mirror_both_o
);

  localparam logic [2:0] ST_CLEAR  = 3'd0;
  localparam logic [2:0] ST_IDLE   = 3'd1;
  localparam logic [2:0] ST_NEIGH  = 3'd2;
  localparam logic [2:0] ST_SCAN1  = 3'd3;
  localparam logic [2:0] ST_SCAN2  = 3'd4;

  logic [2:0]        state_q, state_d;
  logic [IDX_W-1:0]  clr_cnt_q, clr_cnt_d;
  logic [IDX_W-1:0]  pos_q, pos_d;
  logic              force_q, force_d;
  logic              flip_q, flip_d;
  logic [BYTE_W-1:0] video_q, video_d;
  logic [4:0]        own_q, own_d;
  logic              emit_q, emit_d;

  logic              out_valid_q, out_valid_d;
  logic [4:0]        col_q, col_d;
  logic [4:0]        row_q, row_d;
  logic [8:0]        code_q, code_d;
  logic [4:0]        pal_q, pal_d;
  logic              bank_q, bank_d;
  logic              mirror_q, mirror_d;

  logic              v_we, v_re, c_we, c_re, d_we, d_re;
  logic [IDX_W-1:0]  v_addr, c_addr, d_addr;
  logic [BYTE_W-1:0] v_wdata, c_wdata, v_rdata, c_rdata;
  logic              d_wdata, d_rdata;

  logic              slot_free;
  logic              in_fire;
  logic [IDX_W-1:0]  pos_next, pos_prev;

  tas_ram #(.WIDTH(BYTE_W), .DEPTH(TILE_COUNT)) u_video_ram (
    .clk_i  (clk_i),
    .we_i   (v_we),
    .re_i   (v_re),
    .addr_i (v_addr),
    .wdata_i(v_wdata),
    .rdata_o(v_rdata)
  );

  tas_ram #(.WIDTH(BYTE_W), .DEPTH(TILE_COUNT)) u_colour_ram (
    .clk_i  (clk_i),
    .we_i   (c_we),
    .re_i   (c_re),
    .addr_i (c_addr),
    .wdata_i(c_wdata),
    .rdata_o(c_rdata)
  );

  tas_ram #(.WIDTH(1), .DEPTH(TILE_COUNT)) u_dirty_ram (
    .clk_i  (clk_i),
    .we_i   (d_we),
    .re_i   (d_re),
    .addr_i (d_addr),
    .wdata_i(d_wdata),
    .rdata_o(d_rdata)
  );

  // The final scan cycle may only proceed once the output register can take
  // the result, or when there is no result to deliver.
  assign slot_free  = !emit_q || !out_valid_q || out_ready_i;
  assign in_ready_o = (state_q == ST_IDLE) || ((state_q == ST_SCAN2) && slot_free);
  assign in_fire    = in_valid_i && in_ready_o;

  assign pos_next = pos_q + IDX_W'(1);
  assign pos_prev = pos_q - IDX_W'(1);

  always_comb begin
    state_d     = state_q;
    clr_cnt_d   = clr_cnt_q;
    pos_d       = pos_q;
    force_d     = force_q;
    flip_d      = flip_q;
    video_d     = video_q;
    own_d       = own_q;
    emit_d      = emit_q;
    out_valid_d = out_valid_q;
    col_d       = col_q;
    row_d       = row_q;
    code_d      = code_q;
    pal_d       = pal_q;
    bank_d      = bank_q;
    mirror_d    = mirror_q;

    v_we    = 1'b0;
    v_re    = 1'b0;
    c_we    = 1'b0;
    c_re    = 1'b0;
    d_we    = 1'b0;
    d_re    = 1'b0;
    v_addr  = tile_offset_i;
    c_addr  = tile_offset_i;
    d_addr  = tile_offset_i;
    v_wdata = write_byte_i;
    c_wdata = write_byte_i;
    d_wdata = 1'b1;

    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_CLEAR: begin
        v_we      = 1'b1;
        c_we      = 1'b1;
        d_we      = 1'b1;
        v_addr    = clr_cnt_q;
        c_addr    = clr_cnt_q;
        d_addr    = clr_cnt_q;
        v_wdata   = '0;
        c_wdata   = '0;
        d_wdata   = 1'b1;
        clr_cnt_d = clr_cnt_q + IDX_W'(1);
        if (clr_cnt_q == IDX_W'(TILE_COUNT - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
      end
      ST_NEIGH: begin
        // Second half of a colour write: mark the neighbour tile dirty.
        d_we    = 1'b1;
        d_addr  = flip_q ? pos_prev : pos_next;
        d_wdata = 1'b1;
        state_d = ST_IDLE;
      end
      ST_SCAN1: begin
        video_d = v_rdata;
        own_d   = c_rdata[4:0];
        emit_d  = d_rdata || force_q;
        c_re    = 1'b1;
        c_addr  = flip_q ? pos_next : pos_prev;
        d_we    = d_rdata || force_q;
        d_addr  = pos_q;
        d_wdata = 1'b0;
        state_d = ST_SCAN2;
      end
      ST_SCAN2: begin
        if (slot_free) begin
          state_d = ST_IDLE;
          if (emit_q) begin
            out_valid_d = 1'b1;
            col_d       = flip_q ? ~pos_q[4:0] : pos_q[4:0];
            row_d       = flip_q ? ~pos_q[9:5] : pos_q[9:5];
            code_d      = {c_rdata[5], video_q};
            pal_d       = own_q;
            bank_d      = c_rdata[6];
            mirror_d    = flip_q;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (in_fire) begin
      pos_d   = tile_offset_i;
      force_d = force_all_i;
      unique case (req_type_i)
        REQ_VIDEO: begin
          v_we    = 1'b1;
          d_we    = 1'b1;
          d_wdata = 1'b1;
          state_d = ST_IDLE;
        end
        REQ_COLOUR: begin
          c_we    = 1'b1;
          d_we    = 1'b1;
          d_wdata = 1'b1;
          state_d = ST_NEIGH;
        end
        REQ_PORT: begin
          flip_d  = !write_byte_i[7];
          state_d = ST_IDLE;
        end
        REQ_SCAN: begin
          v_re    = 1'b1;
          c_re    = 1'b1;
          d_re    = 1'b1;
          state_d = ST_SCAN1;
        end
        default: begin
          state_d = ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      flip_q      <= 1'b0;
      emit_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      flip_q      <= flip_d;
      emit_q      <= emit_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pos_q    <= pos_d;
    force_q  <= force_d;
    video_q  <= video_d;
    own_q    <= own_d;
    col_q    <= col_d;
    row_q    <= row_d;
    code_q   <= code_d;
    pal_q    <= pal_d;
    bank_q   <= bank_d;
    mirror_q <= mirror_d;
  end

  assign out_valid_o      = out_valid_q;
  assign tile_column_o    = col_q;
  assign tile_row_o       = row_q;
  assign tile_code_o      = code_q;
  assign palette_select_o = pal_q;
  assign graphics_bank_o  = bank_q;
  assign mirror_both_o    = mirror_q;

endmodule
